### design/sha_pkg.sv
// Package: SHA-256 types, constants and a rotate-right function.
`default_nettype none
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;
    localparam int unsigned Rounds     = 64;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_byte;   // write byte into block buffer
        logic [5:0] load_pos;
        logic [7:0] load_data;
        logic       start;       // begin compression of the buffer
        logic       init_hash;   // restore initial hash
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### design/sha_datapath.sv
// Datapath: block buffer, message schedule, round unit and hash state.
`default_nettype none
module sha_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    output sha_pkg::t_status   o_status,
    output logic [31:0]        o_hash [8]
);
    import sha_pkg::*;

    // r_w holds the block as sixteen big-endian words; it then shifts as the schedule
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];
    logic [6:0]  r_round;
    logic        r_busy;
    logic        r_fold;

    logic [31:0] s0, s1, w_next, t1, t2, e, a;

    // Schedule and round logic for the current round
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_next = s1 + r_w[9] + s0 + r_w[0];
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + RoundK[r_round[5:0]] + r_w[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Hash init, byte load and compression sequence: one round per cycle, then fold into hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fold  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else if (i_cmd.init_hash) begin
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else if (i_cmd.start) begin
            r_busy  <= 1'b1;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_fold) begin
            r_fold <= 1'b0;
            r_busy <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_next;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_round <= r_round + 7'd1;
            if (r_round == 7'(Rounds - 1)) r_fold <= 1'b1;
        end else if (i_cmd.load_byte) begin
            // write the byte into its lane, first byte of a word in the top bits
            r_w[i_cmd.load_pos[5:2]][{~i_cmd.load_pos[1:0], 3'b000} +: 8] <= i_cmd.load_data;
        end
    end

    assign o_status.busy = r_busy;
    assign o_hash = r_h;
endmodule
`default_nettype wire

### design/sha_ctrl.sv
// Controller: byte intake, padding sequencer and digest output.
`default_nettype none
module sha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire sha_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sha_pkg::t_out_item     o_item,
    output sha_pkg::t_cmd          o_cmd,
    input  wire sha_pkg::t_status  i_status,
    input  wire logic [31:0]       i_hash [8]
);
    import sha_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StComp = 3'd1;
    localparam logic [2:0] StPad  = 3'd2;
    localparam logic [2:0] StLen  = 3'd3;
    localparam logic [2:0] StFin  = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic        r_eom, n_eom;       // finish pending after compression
    logic        r_last, n_last;     // compression is the final one
    logic        r_cont, n_cont;     // padding goes on into a second block
    logic [63:0] r_len, n_len;
    logic [2:0]  r_idx, n_idx;
    logic        r_wait, n_wait;     // start command pending, issued on entry to StComp
    logic        acc;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != StIdle);
    assign o_valid = (r_state == StOut);
    assign o_item.digest_word = i_hash[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = (r_idx == 3'd7);

    // Next-state and command logic
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_eom   = r_eom;
        n_last  = r_last;
        n_cont  = r_cont;
        n_len   = r_len;
        n_idx   = r_idx;
        n_wait  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            StIdle: begin
                if (acc) begin
                    if (i_item.byte_present) begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.load_pos  = r_pos;
                        o_cmd.load_data = i_item.message_byte;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == 6'd63) begin
                            n_state = StComp;
                            n_wait  = 1'b1;
                            n_eom   = i_item.end_of_message;
                            n_last  = 1'b0;
                        end else if (i_item.end_of_message) begin
                            n_state = StFin;
                        end
                    end else if (i_item.end_of_message) begin
                        n_state = StFin;
                    end
                end
            end
            StComp: begin
                // start on entry, then wait for the datapath
                if (r_wait) begin
                    o_cmd.start = 1'b1;
                end else if (!i_status.busy) begin
                    if (r_last) begin
                        n_state = StOut;
                        n_idx   = '0;
                    end else begin
                        n_state = r_eom ? StFin : (r_cont ? StPad : StIdle);
                        n_eom   = 1'b0;
                    end
                end
            end
            StFin: begin
                // latch total length, write 0x80 marker
                o_cmd.load_byte = 1'b1;
                o_cmd.load_pos  = r_pos;
                o_cmd.load_data = 8'h80;
                n_pos = r_pos + 6'd1;
                n_state = StPad;
            end
            StPad: begin
                // zero fill up to the length field, or to block end
                if (r_pos == 6'(LenPos)) begin
                    n_state = StLen;
                end else if (r_pos == 6'd0 && !r_cont) begin
                    n_state = StComp;
                    n_wait  = 1'b1;
                    n_last  = 1'b0;
                    n_eom   = 1'b0;
                    n_cont  = 1'b1;
                end else begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.load_pos  = r_pos;
                    o_cmd.load_data = 8'h00;
                    n_pos = r_pos + 6'd1;
                end
            end
            StLen: begin
                // emit length bytes big-endian
                o_cmd.load_byte = 1'b1;
                o_cmd.load_pos  = r_pos;
                o_cmd.load_data = r_len[63:56];
                n_len  = {r_len[55:0], 8'd0};
                n_pos  = r_pos + 6'd1;
                n_cont = 1'b0;
                if (r_pos == 6'd63) begin
                    n_state = StComp;
                    n_wait  = 1'b1;
                    n_last  = 1'b1;
                end
            end
            StOut: begin
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.init_hash = 1'b1;
                        n_state = StIdle;
                        n_pos   = '0;
                        n_last  = 1'b0;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // Bit counter kept here: full blocks only; pending bytes are added in len_cap
    logic [63:0] r_bits, n_bits;
    always_comb begin
        n_bits = r_bits;
        if (r_state == StIdle && acc && i_item.byte_present && r_pos == 6'd63) begin
            n_bits = r_bits + 64'd512;
        end
        if (r_state == StOut && !i_stall && r_idx == 3'd7) n_bits = '0;
    end

    // Length captured when the marker is written
    logic [63:0] len_cap;
    assign len_cap = r_bits + {55'd0, r_pos, 3'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_pos   <= '0;
            r_eom   <= 1'b0;
            r_last  <= 1'b0;
            r_cont  <= 1'b0;
            r_idx   <= '0;
            r_wait  <= 1'b0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_eom   <= n_eom;
            r_last  <= n_last;
            r_cont  <= n_cont;
            r_idx   <= n_idx;
            r_wait  <= n_wait;
            r_bits  <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == StFin) r_len <= len_cap;
        else r_len <= n_len;
    end
endmodule
`default_nettype wire

### design/sha256_hash_engine.sv
// Top level: SHA-256 byte-stream hash engine.
//  channel | direction | payload     | handshake
//  in      | input     | t_in_item   | i_valid / o_stall
//  out     | output    | t_out_item  | o_valid / i_stall
// The 64th byte of a block starts the one-round-per-cycle compression unit.
// End of message adds the pad fill, one or two compressions, then eight
// digest items. Reset is synchronous and restores the initial hash values.
// The input stalls while padding, compressing or emitting the digest.
`default_nettype none
module sha256_hash_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire sha_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output sha_pkg::t_out_item      o_item
);
    import sha_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] hash [8];

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_valid, .i_stall, .o_item,
        .o_cmd(cmd), .i_status(status), .i_hash(hash)
    );

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .o_hash(hash)
    );
endmodule
`default_nettype wire

### design/sha_checker.sv
// Checker: port-level properties of the hash engine, bound to the top level.
`default_nettype none
module sha_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire sha_pkg::t_out_item o_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item)) else $error("out held");
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open during digest");
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_item.last_word |=> o_valid &&
        o_item.word_index == $past(o_item.word_index) + 3'd1) else $error("index");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_word == (o_item.word_index == 3'd7))) else $error("last");
endmodule

bind sha256_hash_engine sha_checker u_chk (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_item
);
`default_nettype wire
